// File: rtl/jtok_pkg.sv
// Shared types and token codes of the JSON tokenizer.
package jtok_pkg;

  typedef enum logic [3:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_COMMA    = 4'd4,
    KIND_COLON    = 4'd5,
    KIND_STRING   = 4'd6,
    KIND_DOUBLE   = 4'd7,
    KIND_INTEGRAL = 4'd8,
    KIND_BOOLEAN  = 4'd9,
    KIND_NULL     = 4'd10,
    KIND_END      = 4'd11,
    KIND_ERROR    = 4'd12
  } token_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_UNKNOWN_CHAR = 4'd1,
    ERR_BAD_LITERAL  = 4'd2,
    ERR_BAD_ESCAPE   = 4'd3,
    ERR_UNTERMINATED = 4'd4,
    ERR_MISSING_DIG  = 4'd5,
    ERR_LEADING_ZERO = 4'd6,
    ERR_BAD_FRACTION = 4'd7,
    ERR_BAD_EXPONENT = 4'd8,
    ERR_TOO_LONG     = 4'd9
  } error_kind_e;

  // One token as it leaves the back end.
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  err;
    logic [31:0] start;
    logic [31:0] length;
    logic        last;
  } token_t;

  localparam int unsigned TokenWidth = $bits(token_t);

  // Literal letters, indexed by kind (null, true, false) and position.
  function automatic logic [7:0] literal_char(input logic [1:0] kind,
                                              input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    case (kind)
      2'd0: begin
        case (pos)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'd0;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'd0;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] literal_len(input logic [1:0] kind);
    return (kind == 2'd0 || kind == 2'd1) ? 3'd4 : 3'd5;
  endfunction

endpackage

// File: rtl/jtok_lexer.sv
// Front end: lexer state machine that turns bytes into up to three tokens per word.
module jtok_lexer #(
  parameter int unsigned OffsetWidth = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           text_byte_i,
  input  logic                 has_byte_i,
  input  logic                 eod_i,
  output logic                 grp_valid_o,
  input  logic                 grp_ready_i,
  output jtok_pkg::token_t     grp_tok_o [3],
  output logic [1:0]           grp_cnt_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_LIT, M_STR, M_ESC, M_HEX, M_SIGN, M_ZERO, M_INT,
    M_DOT, M_FRAC, M_E, M_ESIGN, M_EXP, M_ERR
  } mode_e;

  localparam logic [OffsetWidth-1:0] OffMax = '1;

  mode_e                  mode_q, mode_d;
  logic [OffsetWidth-1:0] off_q, off_d, beg_q, beg_d;
  logic [2:0]             lprog_q, lprog_d;
  logic [1:0]             lkind_q, lkind_d;
  logic [2:0]             hex_q, hex_d;
  logic                   dbl_q, dbl_d;

  // Output group register; the front moves on while this register is empty or the queue has room to take it.
  logic                   gv_q;
  jtok_pkg::token_t       gt_q [3];
  jtok_pkg::token_t       gt_d [3];
  logic [1:0]             gc_q, gc_d;

  logic accept;
  assign in_ready_o = !gv_q || grp_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign grp_valid_o = gv_q;
  assign grp_tok_o   = gt_q;
  assign grp_cnt_o   = gc_q;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [31:0] trunc(input logic [OffsetWidth-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  always_comb begin
    logic [7:0]             c;
    logic [OffsetWidth-1:0] p;
    logic                   rescan;
    mode_d  = mode_q;
    off_d   = off_q;
    beg_d   = beg_q;
    lprog_d = lprog_q;
    lkind_d = lkind_q;
    hex_d   = hex_q;
    dbl_d   = dbl_q;
    gc_d    = 2'd0;
    for (int i = 0; i < 3; i++) gt_d[i] = '0;
    c = text_byte_i;
    p = off_q;
    rescan = 1'b0;

    if (has_byte_i && mode_q != M_ERR) begin
      if (off_q == OffMax) begin
        gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_TOO_LONG, trunc(OffMax), 32'd0, 1'b0};
        gc_d = gc_d + 2'd1;
        mode_d = M_ERR;
      end else begin
        unique case (mode_q) inside
          M_LIT: begin
            if (lprog_q < jtok_pkg::literal_len(lkind_q) &&
                c == jtok_pkg::literal_char(lkind_q, lprog_q)) begin
              lprog_d = lprog_q + 3'd1;
              if (lprog_d == jtok_pkg::literal_len(lkind_q)) begin
                gt_d[gc_d] = '{(lkind_q == 2'd0) ? jtok_pkg::KIND_NULL : jtok_pkg::KIND_BOOLEAN,
                               jtok_pkg::ERR_NONE, trunc(beg_q), trunc(p + 1'b1 - beg_q), 1'b0};
                gc_d = gc_d + 2'd1;
                mode_d = M_IDLE;
              end
            end else begin
              gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_BAD_LITERAL, trunc(p), 32'd0, 1'b0};
              gc_d = gc_d + 2'd1;
              mode_d = M_ERR;
            end
          end
          M_STR: begin
            if (c == "\\") mode_d = M_ESC;
            else if (c == "\"") begin
              gt_d[gc_d] = '{jtok_pkg::KIND_STRING, jtok_pkg::ERR_NONE, trunc(beg_q + 1'b1),
                             trunc(p - beg_q - 1'b1), 1'b0};
              gc_d = gc_d + 2'd1;
              mode_d = M_IDLE;
            end
          end
          M_ESC: begin
            if (c == "u") begin
              hex_d = 3'd4;
              mode_d = M_HEX;
            end else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                         c == "n" || c == "r" || c == "t") begin
              mode_d = M_STR;
            end else begin
              gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_BAD_ESCAPE, trunc(p), 32'd0, 1'b0};
              gc_d = gc_d + 2'd1;
              mode_d = M_ERR;
            end
          end
          M_HEX: begin
            if (is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
              hex_d = (hex_q != 3'd0) ? hex_q - 3'd1 : 3'd0;
              if (hex_d == 3'd0) mode_d = M_STR;
            end else begin
              gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_BAD_ESCAPE, trunc(p), 32'd0, 1'b0};
              gc_d = gc_d + 2'd1;
              mode_d = M_ERR;
            end
          end
          M_SIGN: begin
            if (is_dig(c)) mode_d = (c == "0") ? M_ZERO : M_INT;
            else begin
              gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_MISSING_DIG, trunc(p), 32'd0, 1'b0};
              gc_d = gc_d + 2'd1;
              mode_d = M_ERR;
            end
          end
          M_ZERO, M_INT: begin
            if (is_dig(c)) begin
              if (mode_q == M_ZERO) begin
                gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_LEADING_ZERO, trunc(p),
                               32'd0, 1'b0};
                gc_d = gc_d + 2'd1;
                mode_d = M_ERR;
              end
            end else if (c == ".") begin
              dbl_d = 1'b1;
              mode_d = M_DOT;
            end else if (c == "e" || c == "E") begin
              dbl_d = 1'b1;
              mode_d = M_E;
            end else rescan = 1'b1;
          end
          M_DOT: begin
            if (is_dig(c)) mode_d = M_FRAC;
            else begin
              gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_BAD_FRACTION, trunc(p), 32'd0, 1'b0};
              gc_d = gc_d + 2'd1;
              mode_d = M_ERR;
            end
          end
          M_FRAC: begin
            if (is_dig(c)) mode_d = M_FRAC;
            else if (c == "e" || c == "E") mode_d = M_E;
            else rescan = 1'b1;
          end
          M_E: begin
            if (c == "+" || c == "-") mode_d = M_ESIGN;
            else if (is_dig(c)) mode_d = M_EXP;
            else begin
              gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_BAD_EXPONENT, trunc(p), 32'd0, 1'b0};
              gc_d = gc_d + 2'd1;
              mode_d = M_ERR;
            end
          end
          M_ESIGN: begin
            if (is_dig(c)) mode_d = M_EXP;
            else begin
              gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_BAD_EXPONENT, trunc(p), 32'd0, 1'b0};
              gc_d = gc_d + 2'd1;
              mode_d = M_ERR;
            end
          end
          M_EXP: begin
            if (!is_dig(c)) rescan = 1'b1;
          end
          M_ERR: mode_d = M_ERR;
          default: rescan = 1'b1;
        endcase

        // A finished number is emitted, and its terminating byte is lexed afresh.
        if (rescan) begin
          if (mode_q != M_IDLE) begin
            gt_d[gc_d] = '{dbl_q ? jtok_pkg::KIND_DOUBLE : jtok_pkg::KIND_INTEGRAL,
                           jtok_pkg::ERR_NONE, trunc(beg_q), trunc(p - beg_q), 1'b0};
            gc_d = gc_d + 2'd1;
            mode_d = M_IDLE;
          end
          case (c) inside
            " ", "\t", "\n", "\r": ;
            "{", "}", "[", "]", ",", ":": begin
              gt_d[gc_d].kind = (c == "{") ? jtok_pkg::KIND_LBRACE :
                                (c == "}") ? jtok_pkg::KIND_RBRACE :
                                (c == "[") ? jtok_pkg::KIND_LBRACKET :
                                (c == "]") ? jtok_pkg::KIND_RBRACKET :
                                (c == ",") ? jtok_pkg::KIND_COMMA : jtok_pkg::KIND_COLON;
              gt_d[gc_d].err    = jtok_pkg::ERR_NONE;
              gt_d[gc_d].start  = trunc(p);
              gt_d[gc_d].length = 32'd1;
              gc_d = gc_d + 2'd1;
            end
            "\"": begin
              beg_d = p;
              mode_d = M_STR;
            end
            "n", "t", "f": begin
              lkind_d = (c == "n") ? 2'd0 : (c == "t") ? 2'd1 : 2'd2;
              lprog_d = 3'd1;
              beg_d = p;
              mode_d = M_LIT;
            end
            default: begin
              if (c == "-" || is_dig(c)) begin
                beg_d = p;
                dbl_d = 1'b0;
                mode_d = (c == "-") ? M_SIGN : (c == "0") ? M_ZERO : M_INT;
              end else begin
                gt_d[gc_d] = '{jtok_pkg::KIND_ERROR, jtok_pkg::ERR_UNKNOWN_CHAR, trunc(p),
                               32'd0, 1'b0};
                gc_d = gc_d + 2'd1;
                mode_d = M_ERR;
              end
            end
          endcase
        end
      end
    end
    if (has_byte_i && off_q != OffMax) off_d = off_q + 1'b1;

    // End of document: close the pending token, add the end token, restart.
    if (eod_i) begin
      unique case (mode_d) inside
        M_LIT, M_ESC, M_HEX, M_SIGN, M_DOT, M_E, M_ESIGN, M_STR: begin
          gt_d[gc_d].kind = jtok_pkg::KIND_ERROR;
          gt_d[gc_d].err  = (mode_d == M_LIT) ? jtok_pkg::ERR_BAD_LITERAL :
                            (mode_d == M_STR) ? jtok_pkg::ERR_UNTERMINATED :
                            (mode_d == M_SIGN) ? jtok_pkg::ERR_MISSING_DIG :
                            (mode_d == M_DOT) ? jtok_pkg::ERR_BAD_FRACTION :
                            (mode_d == M_E || mode_d == M_ESIGN) ? jtok_pkg::ERR_BAD_EXPONENT :
                            jtok_pkg::ERR_BAD_ESCAPE;
          gt_d[gc_d].start  = trunc((mode_d == M_STR) ? beg_d : off_d);
          gt_d[gc_d].length = 32'd0;
          gc_d = gc_d + 2'd1;
        end
        M_ZERO, M_INT, M_FRAC, M_EXP: begin
          gt_d[gc_d] = '{dbl_d ? jtok_pkg::KIND_DOUBLE : jtok_pkg::KIND_INTEGRAL,
                         jtok_pkg::ERR_NONE, trunc(beg_d), trunc(off_d - beg_d), 1'b0};
          gc_d = gc_d + 2'd1;
        end
        default: ;
      endcase
      gt_d[gc_d] = '{jtok_pkg::KIND_END, jtok_pkg::ERR_NONE, trunc(off_d), 32'd0, 1'b0};
      gc_d = gc_d + 2'd1;
      mode_d = M_IDLE;
      off_d = '0;
      beg_d = '0;
      lprog_d = 3'd0;
      lkind_d = 2'd0;
      hex_d = 3'd0;
      dbl_d = 1'b0;
    end
    if (gc_d != 2'd0) gt_d[gc_d - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      off_q   <= '0;
      beg_q   <= '0;
      lprog_q <= 3'd0;
      lkind_q <= 2'd0;
      hex_q   <= 3'd0;
      dbl_q   <= 1'b0;
      gv_q    <= 1'b0;
      gc_q    <= 2'd0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        off_q   <= off_d;
        beg_q   <= beg_d;
        lprog_q <= lprog_d;
        lkind_q <= lkind_d;
        hex_q   <= hex_d;
        dbl_q   <= dbl_d;
        gv_q    <= (gc_d != 2'd0);
        gc_q    <= gc_d;
      end else if (grp_ready_i) begin
        gv_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) gt_q <= gt_d;
  end

endmodule

// File: rtl/jtok_emitter.sv
// Back end: token queue that sends out one token a cycle while the output side is ready.
module jtok_emitter #(
  parameter int unsigned Depth = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             grp_valid_i,
  output logic             grp_ready_o,
  input  jtok_pkg::token_t grp_tok_i [3],
  input  logic [1:0]       grp_cnt_i,
  output logic             tok_valid_o,
  input  logic             tok_ready_i,
  output jtok_pkg::token_t tok_o
);

  localparam int unsigned Aw = $clog2(Depth);

  jtok_pkg::token_t mem_q [Depth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;
  logic             pop;

  // Room for a whole group of three tokens is required before taking it.
  assign grp_ready_o = (cnt_q <= (Aw+1)'(Depth - 3));
  assign tok_valid_o = (cnt_q != '0);
  assign tok_o       = mem_q[rp_q];
  assign pop         = tok_valid_o && tok_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      logic [1:0] push_n;
      push_n = (grp_valid_i && grp_ready_o) ? grp_cnt_i : 2'd0;
      wp_q  <= wp_q + Aw'(push_n);
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_n) - (Aw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_valid_i && grp_ready_o) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < grp_cnt_i) mem_q[wp_q + Aw'(i)] <= grp_tok_i[i];
      end
    end
  end

endmodule

// File: rtl/json_tokenizer.sv
// Top level of the JSON tokenizer.
// Takes one byte a cycle and sustains one word per cycle as long as the output side takes
// tokens about as fast as they are made; an item yields up to three tokens, sent one per
// cycle from an eight-entry token queue, so the queue's drain rate of one token per cycle
// sets the throughput when bursts of tokens pile up. An input word is registered in the lexer's
// group register and then written into the token queue. The lexer classifies each byte combinationally.
module json_tokenizer #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // text_byte[7:0], has_byte[8], end_of_document[9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // token_kind[3:0], error_kind[7:4], token_start[39:8],
                                     // token_length[71:40]
  output logic        m_axis_tlast   // last_of_run
);

  logic             grp_valid, grp_ready;
  jtok_pkg::token_t grp_tok [3];
  logic [1:0]       grp_cnt;
  jtok_pkg::token_t tok;

  jtok_lexer #(.OffsetWidth(OFFSET_WIDTH)) u_lexer (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .text_byte_i(s_axis_tdata[7:0]),
    .has_byte_i (s_axis_tdata[8]),
    .eod_i      (s_axis_tdata[9]),
    .grp_valid_o(grp_valid),
    .grp_ready_i(grp_ready),
    .grp_tok_o  (grp_tok),
    .grp_cnt_o  (grp_cnt)
  );

  jtok_emitter #(.Depth(8)) u_emitter (
    .clk_i, .rst_ni,
    .grp_valid_i(grp_valid),
    .grp_ready_o(grp_ready),
    .grp_tok_i  (grp_tok),
    .grp_cnt_i  (grp_cnt),
    .tok_valid_o(m_axis_tvalid),
    .tok_ready_i(m_axis_tready),
    .tok_o      (tok)
  );

  assign m_axis_tdata = {tok.length, tok.start, tok.err, tok.kind};
  assign m_axis_tlast = tok.last;

endmodule

// File: rtl/jtok_checker.sv
// Port-level checker for the JSON tokenizer and its bind.
module jtok_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Error and end tokens carry zero length.
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:0] == jtok_pkg::KIND_END ||
                      m_axis_tdata[3:0] == jtok_pkg::KIND_ERROR)
    |-> m_axis_tdata[71:40] == 32'd0)
    else $error("end or error token with nonzero length");

  // Only error tokens carry an error code.
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] != jtok_pkg::KIND_ERROR
    |-> m_axis_tdata[7:4] == jtok_pkg::ERR_NONE)
    else $error("error code on non-error token");

  // An end token closes its run.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] == jtok_pkg::KIND_END |-> m_axis_tlast)
    else $error("end token not last of run");

endmodule

bind json_tokenizer jtok_checker u_jtok_checker (
  .clk_i, .rst_ni,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
